// File: rtl/pid_sa_pkg.sv
// ----------------------------------------------------------------------------
// pid_sa_pkg
// Shared types and constants for the PID controller with anti-windup.
// ----------------------------------------------------------------------------
package pid_sa_pkg;

  localparam int KP_W     = 15;
  localparam int KI_W     = 11;
  localparam int KD_W     = 11;
  localparam int LIMIT_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CLAMP_W  = 2;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd4;

  // Reset values
  localparam logic [KP_W-1:0]    KP_RST      = 15'd12800;
  localparam logic [KI_W-1:0]    KI_RST      = 11'd77;
  localparam logic [KD_W-1:0]    KD_RST      = 11'd384;
  localparam logic [LIMIT_W-1:0] OUT_MIN_RST = 16'h8000;
  localparam logic [LIMIT_W-1:0] OUT_MAX_RST = 16'h7FFF;

  // Clamp report codes
  localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
  localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd1;
  localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd2;

  typedef struct packed {
    logic [KP_W-1:0]    kp;
    logic [KI_W-1:0]    ki;
    logic [KD_W-1:0]    kd;
    logic [LIMIT_W-1:0] out_min;
    logic [LIMIT_W-1:0] out_max;
  } cfg_t;

endpackage

// File: rtl/pid_sa_in_if.sv
// ----------------------------------------------------------------------------
// pid_sa_in_if
// Sample channel: setpoint, measured position and velocity, integral clear.
// ----------------------------------------------------------------------------
interface pid_sa_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] setpoint;
  logic signed [DATA_WIDTH-1:0] measured_position;
  logic signed [DATA_WIDTH-1:0] measured_velocity;
  logic                         clear_integral;

  modport source (
    output valid, setpoint, measured_position, measured_velocity, clear_integral,
    input  ready
  );
  modport sink (
    input  valid, setpoint, measured_position, measured_velocity, clear_integral,
    output ready
  );
endinterface

// File: rtl/pid_sa_out_if.sv
// ----------------------------------------------------------------------------
// pid_sa_out_if
// Result channel: clamped drive value and clamp report.
// ----------------------------------------------------------------------------
interface pid_sa_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;
  logic [1:0]                   clamped;

  modport source (
    output valid, drive, clamped,
    input  ready
  );
  modport sink (
    input  valid, drive, clamped,
    output ready
  );
endinterface

// File: rtl/pid_sa_cfg_if.sv
// ----------------------------------------------------------------------------
// pid_sa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pid_sa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: rtl/pid_sa_cfg_regs.sv
// ----------------------------------------------------------------------------
// pid_sa_cfg_regs
// Gain and output limit registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module pid_sa_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  pid_sa_cfg_if.sink       cfg_if,
  output pid_sa_pkg::cfg_t cfg
);
  import pid_sa_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg         = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_KP:      cfg_nxt.kp      = cfg_if.data[KP_W-1:0];
        REG_KI:      cfg_nxt.ki      = cfg_if.data[KI_W-1:0];
        REG_KD:      cfg_nxt.kd      = cfg_if.data[KD_W-1:0];
        REG_OUT_MIN: cfg_nxt.out_min = cfg_if.data[LIMIT_W-1:0];
        REG_OUT_MAX: cfg_nxt.out_max = cfg_if.data[LIMIT_W-1:0];
        default:     cfg_nxt         = cfg_r; // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp      <= KP_RST;
      cfg_r.ki      <= KI_RST;
      cfg_r.kd      <= KD_RST;
      cfg_r.out_min <= OUT_MIN_RST;
      cfg_r.out_max <= OUT_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/pid_sa_datapath.sv
// ----------------------------------------------------------------------------
// pid_sa_datapath
// One PID step: three gain products, integral update and clamp, output clamp
// and back-calculation anti-windup.
// ----------------------------------------------------------------------------
module pid_sa_datapath #(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  pid_sa_pkg::cfg_t              cfg,
  input  logic signed [DATA_WIDTH-1:0]  setpoint,
  input  logic signed [DATA_WIDTH-1:0]  measured_position,
  input  logic signed [DATA_WIDTH-1:0]  measured_velocity,
  input  logic                          clear_integral,
  input  logic signed [DATA_WIDTH-4:0]  integral,
  output logic signed [DATA_WIDTH-4:0]  integral_nxt,
  output logic signed [DATA_WIDTH-1:0]  drive,
  output logic [pid_sa_pkg::CLAMP_W-1:0] clamped
);
  import pid_sa_pkg::*;

  localparam int IW   = DATA_WIDTH - 3;
  localparam int EW   = DATA_WIDTH + 1;
  localparam int PW_P = EW + KP_W + 1;
  localparam int PW_I = EW + KI_W + 1;
  localparam int PW_D = DATA_WIDTH + KD_W + 1;
  localparam int RW   = DATA_WIDTH + 19;
  localparam int HALF = 1 << (DATA_WIDTH - 5);
  localparam logic signed [RW-1:0] HALF_POS = RW'(HALF);
  localparam logic signed [RW-1:0] HALF_NEG = -HALF_POS;

  logic signed [EW-1:0]   err;
  logic signed [PW_P-1:0] prod_p;
  logic signed [PW_I-1:0] prod_i;
  logic signed [PW_D-1:0] prod_d;
  logic signed [RW-1:0]   integ_base;
  logic signed [RW-1:0]   integ_sum;
  logic signed [RW-1:0]   integ_clip;
  logic signed [RW-1:0]   raw;
  logic signed [RW-1:0]   lo;
  logic signed [RW-1:0]   hi;
  logic signed [RW-1:0]   integ_fin;
  logic signed [RW-1:0]   drive_w;

  assign err    = EW'(setpoint) - EW'(measured_position);
  assign prod_p = err * $signed({1'b0, cfg.kp});
  assign prod_i = err * $signed({1'b0, cfg.ki});
  assign prod_d = measured_velocity * $signed({1'b0, cfg.kd});

  assign lo = RW'($signed(cfg.out_min));
  assign hi = RW'($signed(cfg.out_max));

  always_comb begin
    integ_base = clear_integral ? '0 : RW'(integral);
    integ_sum  = integ_base + RW'(prod_i >>> GAIN_FRAC_BITS);
    if (integ_sum > HALF_POS) begin
      integ_clip = HALF_POS;
    end else if (integ_sum < HALF_NEG) begin
      integ_clip = HALF_NEG;
    end else begin
      integ_clip = integ_sum;
    end

    raw = RW'(prod_p >>> GAIN_FRAC_BITS) + integ_clip - RW'(prod_d >>> GAIN_FRAC_BITS);

    drive_w   = raw;
    clamped   = CLAMP_NONE;
    integ_fin = integ_clip;
    // Low test first, so with crossed limits a value below out_min resolves to out_min
    if (raw < lo) begin
      drive_w = lo;
      clamped = CLAMP_LOW;
      if (integ_clip < 0) begin
        integ_fin = integ_clip + (lo - raw);
        if (integ_fin > 0) begin
          integ_fin = '0;
        end
      end
    end else if (raw > hi) begin
      drive_w = hi;
      clamped = CLAMP_HIGH;
      if (integ_clip > 0) begin
        integ_fin = integ_clip - (raw - hi);
        if (integ_fin < 0) begin
          integ_fin = '0;
        end
      end
    end
  end

  assign integral_nxt = integ_fin[IW-1:0];
  assign drive        = drive_w[DATA_WIDTH-1:0];

endmodule

// File: rtl/pid_step_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_step_antiwindup
// PID position controller with clamped integral and anti-windup.
// ----------------------------------------------------------------------------
// Each sample transfer yields one result: drive, the clamped sum of the
// proportional term, the updated integral and the negated velocity term, with
// a clamp report. The block takes one sample per cycle while the output is not
// stalled: a sample lands in the input register, and the single-pass datapath
// (three gain multiplies in parallel, the integral update and the clamps)
// fills the result register and the integral register when the sample advances.
// The integral loop closes inside that one pass. A result waiting on a stalled
// output holds the sample in the input register, so the input takes at most
// one more sample and then stalls until the result drains. Configuration
// writes take effect at once and are to be made while no sample is in flight.
// ----------------------------------------------------------------------------
module pid_step_antiwindup #(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  pid_sa_in_if.sink   in_if,
  pid_sa_out_if.source out_if,
  pid_sa_cfg_if.sink  cfg_if
);
  import pid_sa_pkg::*;

  localparam int IW   = DATA_WIDTH - 3;
  localparam int HALF = 1 << (DATA_WIDTH - 5);
  localparam logic signed [IW-1:0] HALF_POS = IW'(HALF);
  localparam logic signed [IW-1:0] HALF_NEG = -HALF_POS;

  cfg_t cfg;

  logic                         s1_valid_r, s1_valid_nxt;
  logic signed [DATA_WIDTH-1:0] sp_r, pos_r, vel_r;
  logic                         clr_r;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [DATA_WIDTH-1:0] drive_r;
  logic [CLAMP_W-1:0]           clamped_r;
  logic signed [IW-1:0]         integral_r, integral_nxt;
  logic signed [DATA_WIDTH-1:0] drive_c;
  logic [CLAMP_W-1:0]           clamped_c;
  logic                         advance;
  logic                         in_xfer;

  pid_sa_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  pid_sa_datapath #(
    .DATA_WIDTH     (DATA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .cfg               (cfg),
    .setpoint          (sp_r),
    .measured_position (pos_r),
    .measured_velocity (vel_r),
    .clear_integral    (clr_r),
    .integral          (integral_r),
    .integral_nxt      (integral_nxt),
    .drive             (drive_c),
    .clamped           (clamped_c)
  );

  // Advance the sample whenever the result register is free or draining
  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;
  assign in_xfer     = in_if.valid && in_if.ready;

  assign out_if.valid   = out_valid_r;
  assign out_if.drive   = drive_r;
  assign out_if.clamped = clamped_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      integral_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        integral_r <= integral_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sp_r  <= in_if.setpoint;
      pos_r <= in_if.measured_position;
      vel_r <= in_if.measured_velocity;
      clr_r <= in_if.clear_integral;
    end
    if (advance) begin
      drive_r   <= drive_c;
      clamped_r <= clamped_c;
    end
  end

  a_integral_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (integral_r <= HALF_POS) && (integral_r >= HALF_NEG))
    else $error("integral outside its clamp range");

  a_integral_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(integral_r))
    else $error("integral changed without a sample advancing");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r)
    else $error("stalled sample lost from input register");

  a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced sample produced no result");

  a_clamp_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (clamped_r == CLAMP_NONE || clamped_r == CLAMP_LOW ||
                     clamped_r == CLAMP_HIGH))
    else $error("undefined clamp code on result");

endmodule
